// ===== rtl/core/aine_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aine_pkg;

  // width of body and chunk length counters
  localparam int unsigned LEN_BITS = 64;

  // tags as they sit in the window, first byte in the top position
  localparam logic [31:0] TAG_BODY  = "File";
  localparam logic [31:0] TAG_HNAME = "hnfn";
  localparam logic [31:0] TAG_INAME = "info";
  localparam logic [31:0] TAG_SEG   = "segm";
  localparam logic [31:0] TAG_ADL   = "adlr";

  // bytes skipped between tag and name length, and length field widths in bytes
  localparam logic [4:0] HNFN_GAP = 5'd12;
  localparam logic [4:0] INFO_GAP = 5'd28;
  localparam logic [4:0] LEN_FIELD_BYTES = 5'd8;
  localparam logic [4:0] NLEN_FIELD_BYTES = 5'd2;

  // parser modes, one-hot
  typedef enum logic [10:0] {
    M_OUT_SCAN = 11'b000_0000_0001,
    M_BODY_LEN = 11'b000_0000_0010,
    M_H_SKIP   = 11'b000_0000_0100,
    M_H_NLEN   = 11'b000_0000_1000,
    M_H_UNITS  = 11'b000_0001_0000,
    M_IN_SCAN  = 11'b000_0010_0000,
    M_I_SKIP   = 11'b000_0100_0000,
    M_I_NLEN   = 11'b000_1000_0000,
    M_I_UNITS  = 11'b001_0000_0000,
    M_C_LEN    = 11'b010_0000_0000,
    M_C_SKIP   = 11'b100_0000_0000
  } mode_e;

  // one extracted name unit
  typedef struct packed {
    logic [15:0] name_unit;
    logic        name_kind;
    logic        last_unit;
    logic        empty_name;
  } res_t;

  // clamp a received 64-bit length to the counter width
  function automatic logic [LEN_BITS-1:0] sat_len(input logic [63:0] v);
    logic [63:0] lim;
    lim = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_BITS);
    if (v > lim) begin
      sat_len = '1;
    end else begin
      sat_len = v[LEN_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/aine_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// byte stream channel
interface aine_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_index;

  modport source (output valid, output data_byte, output end_of_index, input ready);
  modport sink   (input valid, input data_byte, input end_of_index, output ready);
endinterface

// name unit channel
interface aine_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] name_unit;
  logic        name_kind;
  logic        last_unit;
  logic        empty_name;

  modport source (output valid, output name_unit, output name_kind, output last_unit,
                  output empty_name, input ready);
  modport sink   (input valid, input name_unit, input name_kind, input last_unit,
                  input empty_name, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/aine_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aine_parser (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          end_of_index_i,
  output logic               res_valid_o,
  output aine_pkg::res_t     res_o
);
  import aine_pkg::*;

  // parser state
  logic [31:0]         win_q, win_d;
  logic [2:0]          fill_q, fill_d;
  mode_e               mode_q, mode_d;
  logic [4:0]          cnt_q, cnt_d;
  logic [63:0]         lsh_q, lsh_d;
  logic [LEN_BITS-1:0] skip_q, skip_d;
  logic [LEN_BITS-1:0] body_q, body_d;
  logic [15:0]         nrem_q, nrem_d;
  logic [7:0]          low_q, low_d;

  // step temporaries
  logic                inner, hk, ends;
  mode_e               scan_back;
  logic [31:0]         win_n;
  logic [2:0]          fill_n;
  logic [4:0]          cnt_inc;
  logic [63:0]         lsh_n;
  logic [LEN_BITS-1:0] len_sat;
  logic [LEN_BITS-1:0] skip_dec, body_dec;
  logic [15:0]         nrem_dec;
  logic                unit_fin;
  logic                go;
  mode_e               go_mode;
  logic                res_vld;
  res_t                res;

  assign inner = (mode_q == M_IN_SCAN) || (mode_q == M_I_SKIP) || (mode_q == M_I_NLEN) ||
                 (mode_q == M_I_UNITS) || (mode_q == M_C_LEN) || (mode_q == M_C_SKIP);
  assign hk        = !inner;
  assign ends      = end_of_index_i || (inner && (body_q[LEN_BITS-1:1] == '0));
  assign scan_back = hk ? M_OUT_SCAN : M_IN_SCAN;

  // shared datapath pieces
  assign win_n    = {win_q[23:0], data_byte_i};
  assign fill_n   = (fill_q < 3'd4) ? fill_q + 3'd1 : fill_q;
  assign cnt_inc  = cnt_q + 5'd1;
  assign lsh_n    = lsh_q | ({56'd0, data_byte_i} << {cnt_q[2:0], 3'b000});
  assign len_sat  = sat_len(lsh_n);
  assign skip_dec = (skip_q != '0) ? skip_q - LEN_BITS'(1) : skip_q;
  assign body_dec = (body_q != '0) ? body_q - LEN_BITS'(1) : body_q;
  assign nrem_dec = (nrem_q != 16'd0) ? nrem_q - 16'd1 : nrem_q;
  assign unit_fin = (nrem_dec == 16'd0) || ends;

  // one byte step
  always_comb begin
    win_d   = win_q;
    fill_d  = fill_q;
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    lsh_d   = lsh_q;
    skip_d  = skip_q;
    body_d  = body_q;
    nrem_d  = nrem_q;
    low_d   = low_q;
    go      = 1'b0;
    go_mode = M_OUT_SCAN;
    res_vld = 1'b0;
    res     = '{name_unit: 16'd0, name_kind: hk, last_unit: 1'b1, empty_name: 1'b0};

    unique case (mode_q)
      M_BODY_LEN, M_C_LEN: begin
        lsh_d = lsh_n;
        cnt_d = cnt_inc;
        if (cnt_inc >= LEN_FIELD_BYTES) begin
          go = 1'b1;
          if (mode_q == M_BODY_LEN) begin
            go_mode = (len_sat == '0) ? M_OUT_SCAN : M_IN_SCAN;
            if (len_sat != '0) begin
              body_d = len_sat;
            end
          end else begin
            go_mode = (len_sat == '0) ? M_IN_SCAN : M_C_SKIP;
            if (len_sat != '0) begin
              skip_d = len_sat;
            end
          end
        end
      end
      M_H_SKIP, M_I_SKIP: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= (hk ? HNFN_GAP : INFO_GAP)) begin
          go      = 1'b1;
          go_mode = hk ? M_H_NLEN : M_I_NLEN;
        end
      end
      M_H_NLEN, M_I_NLEN: begin
        lsh_d = lsh_n;
        cnt_d = cnt_inc;
        if (cnt_inc >= NLEN_FIELD_BYTES) begin
          go = 1'b1;
          if ((lsh_n[15:0] == 16'd0) || ends) begin
            res_vld        = 1'b1;
            res.empty_name = 1'b1;
            nrem_d         = 16'd0;
            go_mode        = scan_back;
          end else begin
            nrem_d  = lsh_n[15:0];
            go_mode = hk ? M_H_UNITS : M_I_UNITS;
          end
        end
      end
      M_H_UNITS, M_I_UNITS: begin
        if (!cnt_q[0]) begin
          // low byte of a unit
          low_d = data_byte_i;
          cnt_d = 5'd1;
          if (ends) begin
            res_vld       = 1'b1;
            res.name_unit = {8'd0, data_byte_i};
            nrem_d        = 16'd0;
            go            = 1'b1;
            go_mode       = scan_back;
          end
        end else begin
          // high byte completes the unit
          res_vld       = 1'b1;
          res.name_unit = {data_byte_i, low_q};
          res.last_unit = unit_fin;
          cnt_d         = 5'd0;
          nrem_d        = unit_fin ? 16'd0 : nrem_dec;
          go            = unit_fin;
          go_mode       = scan_back;
        end
      end
      M_C_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          go      = 1'b1;
          go_mode = M_IN_SCAN;
        end
      end
      default: begin
        // tag scan, outer or inner
        win_d  = win_n;
        fill_d = fill_n;
        if (fill_n >= 3'd4) begin
          if (!inner && (win_n == TAG_BODY)) begin
            go = 1'b1; go_mode = M_BODY_LEN;
          end else if (!inner && (win_n == TAG_HNAME)) begin
            go = 1'b1; go_mode = M_H_SKIP;
          end else if (inner && (win_n == TAG_INAME)) begin
            go = 1'b1; go_mode = M_I_SKIP;
          end else if (inner && ((win_n == TAG_SEG) || (win_n == TAG_ADL))) begin
            go = 1'b1; go_mode = M_C_LEN;
          end
        end
      end
    endcase

    // mode entry clears the field and tag trackers
    if (go) begin
      mode_d = go_mode;
      cnt_d  = 5'd0;
      lsh_d  = 64'd0;
      win_d  = 32'd0;
      fill_d = 3'd0;
    end

    // end of index or end of body
    if (end_of_index_i) begin
      mode_d = M_OUT_SCAN;
      cnt_d  = 5'd0;
      lsh_d  = 64'd0;
      win_d  = 32'd0;
      fill_d = 3'd0;
      skip_d = '0;
      body_d = '0;
      nrem_d = 16'd0;
      low_d  = 8'd0;
    end else if (inner) begin
      body_d = body_dec;
      if (body_dec == '0) begin
        skip_d = '0;
        nrem_d = 16'd0;
        mode_d = M_OUT_SCAN;
        cnt_d  = 5'd0;
        lsh_d  = 64'd0;
        win_d  = 32'd0;
        fill_d = 3'd0;
      end
    end
  end

  // state registers, updated per accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= 32'd0;
      fill_q <= 3'd0;
      mode_q <= M_OUT_SCAN;
      cnt_q  <= 5'd0;
      lsh_q  <= 64'd0;
      skip_q <= '0;
      body_q <= '0;
      nrem_q <= 16'd0;
      low_q  <= 8'd0;
    end else if (accept_i) begin
      win_q  <= win_d;
      fill_q <= fill_d;
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      lsh_q  <= lsh_d;
      skip_q <= skip_d;
      body_q <= body_d;
      nrem_q <= nrem_d;
      low_q  <= low_d;
    end
  end

  assign res_valid_o = accept_i && res_vld;
  assign res_o       = res;

`ifndef SYNTHESIS
  // the last byte of an index always leaves the parser idle
  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && end_of_index_i |=> (mode_q == M_OUT_SCAN) && (body_q == '0))
    else $error("parser not idle after end of index");

  // inside a body there is always at least one byte left
  a_body_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inner |-> (body_q != '0))
    else $error("inner mode with empty body count");

  // unit modes always have a unit outstanding
  a_units_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_H_UNITS) || (mode_q == M_I_UNITS) |-> (nrem_q != 16'd0))
    else $error("unit mode with no units left");

  // skip counter never runs past the info gap
  a_skip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_I_SKIP) || (mode_q == M_H_SKIP) |-> (cnt_q < INFO_GAP))
    else $error("skip counter overran gap");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/aine_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module aine_out_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire aine_pkg::res_t push_data_i,
  output logic                full_o,
  aine_out_if.source          out_o
);
  import aine_pkg::*;

  // two-entry result buffer
  res_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       pop;
  res_t       head;

  assign pop    = out_o.valid && out_o.ready;
  assign full_o = (cnt_q == 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  // head entry drives the channel
  assign head             = mem_q[rd_ptr_q];
  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.name_unit  = head.name_unit;
  assign out_o.name_kind  = head.name_kind;
  assign out_o.last_unit  = head.last_unit;
  assign out_o.empty_name = head.empty_name;

endmodule

`default_nettype wire

// ===== rtl/core/archive_index_name_extractor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result is written into the result buffer as the byte that causes it transfers.
// One byte per cycle unless the buffer is full; the parser state advances once per byte.
// A two-entry result buffer lets bytes keep flowing while one result waits at the output.
// Reset (rst_ni low, asynchronous): parser back to outer tag scan, result buffer empty.

module archive_index_name_extractor_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  aine_in_if.sink     in_i,
  aine_out_if.source  out_o
);
  import aine_pkg::*;

  logic accept;
  logic res_valid;
  res_t res;
  logic full;

  assign in_i.ready = !full;
  assign accept     = in_i.valid && in_i.ready;

  // per-byte parser
  aine_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (in_i.data_byte),
    .end_of_index_i (in_i.end_of_index),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  // result buffer
  aine_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (full),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
